// ===== rtl/tcps_pkg.sv =====
// Package with shared types and constants for the period statistics block.
`default_nettype none
package tcps_pkg;

  localparam int unsigned SampleBitsDef   = 16;
  localparam int unsigned FractionBitsDef = 16;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned IndexW  = 32;
  localparam int unsigned SumW    = 64;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    PH_FIRST    = 3'd0,
    PH_WAIT_LOW = 3'd1,
    PH_ARMED    = 3'd2,
    PH_HIGH     = 3'd3,
    PH_LOW      = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_REF   = 2'd1,
    EV_FALL  = 2'd2,
    EV_CLOSE = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_DIV    = 3'd1,
    BK_APPLY  = 3'd2,
    BK_MEANP  = 3'd3,
    BK_MEANO  = 3'd4,
    BK_EMIT   = 3'd5,
    BK_SETTLE = 3'd6
  } back_e;

  // One classified item handed from the front to the back.
  typedef struct packed {
    event_e       ev;
    logic         last;
    logic [IndexW-1:0] idx;
    logic [32:0]  num;
    logic [32:0]  den;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/threshold_crossing_period_stats.sv =====
// Top level of the threshold crossing period statistics block.
`default_nettype none
// Samples arrive through a queue-style push port and are classified
// combinationally by the front part (threshold compare, crossing detection,
// sample index); each classified sample goes through a two-entry command
// queue to the back part. A sample without a crossing that is not last
// leaves the back part idle. A crossing runs a shared restoring divider
// one quotient bit per cycle, and the back part takes no further sample
// until the divider is done. A last sample passes a settle state for the
// statistics, then, if any period was seen, computes both means with the
// same divider; then the summary is registered and offered on the result
// port until popped. Samples of the next record keep flowing while a
// summary waits; only a further last sample waits for that transfer. The
// threshold register must be written while idle.
module threshold_crossing_period_stats #(
  parameter int unsigned SAMPLE_BITS   = tcps_pkg::SampleBitsDef,
  parameter int unsigned FRACTION_BITS = tcps_pkg::FractionBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   threshold_level_we_i,
  input  wire logic [SAMPLE_BITS-1:0] threshold_level_i,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                   last_sample_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [31:0]                 period_count_o,
  output logic [47:0]                 mean_period_o,
  output logic [47:0]                 mean_on_time_o,
  output logic [47:0]                 shortest_period_o,
  output logic [31:0]                 shortest_period_at_o,
  output logic [47:0]                 longest_period_o,
  output logic [31:0]                 longest_period_at_o,
  output logic [47:0]                 shortest_on_time_o,
  output logic [31:0]                 shortest_on_time_at_o,
  output logic [47:0]                 longest_on_time_o,
  output logic [31:0]                 longest_on_time_at_o
);
  import tcps_pkg::*;

  logic [SAMPLE_BITS-1:0] thr_q;
  cmd_t front_cmd, q_cmd;
  logic q_empty, q_pop, accept;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= '0;
    else if (threshold_level_we_i) thr_q <= threshold_level_i;
  end

  tcps_front #(.SampleBits(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni, .thr_i(thr_q), .valid_i(accept),
    .sample_i, .last_i(last_sample_i), .cmd_o(front_cmd)
  );

  tcps_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(front_cmd), .full_o(full),
    .pop_i(q_pop), .data_o(q_cmd), .empty_o(q_empty)
  );

  tcps_back #(.FractionBits(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(!q_empty), .cmd_i(q_cmd), .cmd_pop_o(q_pop),
    .pop_i(pop), .empty_o(empty),
    .period_count_o, .mean_period_o, .mean_on_time_o,
    .shortest_period_o, .shortest_period_at_o,
    .longest_period_o, .longest_period_at_o,
    .shortest_on_time_o, .shortest_on_time_at_o,
    .longest_on_time_o, .longest_on_time_at_o
  );
endmodule
`default_nettype wire

// ===== rtl/tcps_front.sv =====
// Front part: threshold compare, crossing detection and the index counter.
`default_nettype none
module tcps_front #(
  parameter int unsigned SampleBits = tcps_pkg::SampleBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [SampleBits-1:0] thr_i,
  input  wire logic                  valid_i,
  input  wire logic [SampleBits-1:0] sample_i,
  input  wire logic                  last_i,
  output tcps_pkg::cmd_t             cmd_o
);
  import tcps_pkg::*;

  phase_e               phase_q, phase_d;
  logic [SampleBits-1:0] prev_q;
  logic [IndexW-1:0]     idx_q;
  logic                  above;
  logic signed [32:0]    cur_x, thr_x, prev_x;

  assign cur_x  = 33'(signed'(sample_i));
  assign thr_x  = 33'(signed'(thr_i));
  assign prev_x = 33'(signed'(prev_q));
  assign above  = cur_x > thr_x;

  always_comb begin
    phase_d = phase_q;
    cmd_o.ev = EV_NONE;
    cmd_o.last = last_i;
    cmd_o.idx = idx_q;
    cmd_o.num = 33'(thr_x - prev_x);
    cmd_o.den = 33'(cur_x - prev_x);
    case (phase_q)
      PH_WAIT_LOW: if (!above) phase_d = PH_ARMED;
      PH_ARMED: if (above) begin
        phase_d = PH_HIGH;
        cmd_o.ev = EV_REF;
      end
      PH_HIGH: if (!above) begin
        phase_d = PH_LOW;
        cmd_o.ev = EV_FALL;
        cmd_o.num = 33'(prev_x - thr_x);
        cmd_o.den = 33'(prev_x - cur_x);
      end
      PH_LOW: if (above) begin
        phase_d = PH_HIGH;
        cmd_o.ev = EV_CLOSE;
      end
      default: phase_d = above ? PH_WAIT_LOW : PH_ARMED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      prev_q  <= '0;
      idx_q   <= '0;
    end else if (valid_i) begin
      if (last_i) begin
        phase_q <= PH_FIRST;
        prev_q  <= '0;
        idx_q   <= '0;
      end else begin
        phase_q <= phase_d;
        prev_q  <= sample_i;
        if (idx_q != '1) idx_q <= idx_q + 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && last_i |=> idx_q == '0)
    else $error("index not cleared after last sample");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ev != EV_NONE |-> cmd_o.den != '0 && !cmd_o.den[32])
    else $error("crossing divisor not positive");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ev == EV_CLOSE |-> phase_q == PH_LOW)
    else $error("period closed outside low phase");
endmodule
`default_nettype wire

// ===== rtl/tcps_queue.sv =====
// Short command queue between the front and the back.
`default_nettype none
module tcps_queue #(
  parameter int unsigned Depth = tcps_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  tcps_pkg::cmd_t  data_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output tcps_pkg::cmd_t  data_o,
  output logic            empty_o
);
  import tcps_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;

  assign full_o  = cnt_q == (AW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) if (push_i && !full_o) mem_q[wr_q] <= data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o)
        wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (pop_i && !empty_o)
        rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i && !full_o) - (AW+1)'(pop_i && !empty_o);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tcps_back.sv =====
// Back part: shared serial divider, statistics update and summary output.
`default_nettype none
module tcps_back #(
  parameter int unsigned FractionBits = tcps_pkg::FractionBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_valid_i,
  input  tcps_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output logic [31:0]                period_count_o,
  output logic [47:0]                mean_period_o,
  output logic [47:0]                mean_on_time_o,
  output logic [47:0]                shortest_period_o,
  output logic [31:0]                shortest_period_at_o,
  output logic [47:0]                longest_period_o,
  output logic [31:0]                longest_period_at_o,
  output logic [47:0]                shortest_on_time_o,
  output logic [31:0]                shortest_on_time_at_o,
  output logic [47:0]                longest_on_time_o,
  output logic [31:0]                longest_on_time_at_o
);
  import tcps_pkg::*;
  // Divider: quotient width covers both the crossing fraction and 64-bit means.
  localparam int unsigned QW = SumW;
  localparam int unsigned CW = $clog2(QW + 1);

  back_e            st_q, st_d;
  cmd_t             cmd_q;
  logic [QW-1:0]    quo_q;
  logic [QW:0]      rem_q;
  logic [QW-1:0]    dvd_q;
  logic [IndexW:0]  dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             div_start;
  logic [QW-1:0]    div_dvd;
  logic [IndexW:0]  div_dvs;
  logic [CW-1:0]    div_len;
  logic [QW:0]      rem_sh;
  logic             rem_ge;

  logic [TimeW-1:0]  ref_q, fall_q;
  logic [IndexW-1:0] seen_q;
  logic [SumW-1:0]   psum_q, osum_q;
  logic [TimeW-1:0]  minp_q, maxp_q, mino_q, maxo_q;
  logic [IndexW-1:0] minp_at_q, maxp_at_q, mino_at_q, maxo_at_q;
  logic              out_full_q;
  logic [TimeW-1:0]  meanp_q;

  logic [TimeW-1:0]  ctime, per, ont;
  logic [SumW:0]     psum_n, osum_n;
  logic [TimeW-1:0]  mean_sat;
  logic              clear_stats;

  assign rem_sh = {rem_q[QW-1:0], dvd_q[QW-1]};
  assign rem_ge = rem_sh >= (QW+1)'(dvs_q);
  assign ctime  = TimeW'({cmd_q.idx - 1'b1, FractionBits'(0)}) + TimeW'(quo_q);
  assign per    = ctime - ref_q;
  assign ont    = fall_q - ref_q;
  assign psum_n = {1'b0, psum_q} + (SumW+1)'(per);
  assign osum_n = {1'b0, osum_q} + (SumW+1)'(ont);
  assign mean_sat = (quo_q[QW-1:TimeW] != '0) ? '1 : quo_q[TimeW-1:0];

  always_comb begin
    st_d = st_q;
    cmd_pop_o = 1'b0;
    div_start = 1'b0;
    // The dividend is left-aligned so the shortened run sees the numerator first.
    div_dvd = {cmd_i.num[31:0], (QW-32)'(0)};
    div_dvs = cmd_i.den;
    div_len = CW'(32 + FractionBits);
    clear_stats = 1'b0;
    case (st_q)
      BK_IDLE: if (cmd_valid_i && !(cmd_i.last && out_full_q)) begin
        cmd_pop_o = 1'b1;
        if (cmd_i.ev != EV_NONE) begin
          div_start = 1'b1;
          st_d = BK_DIV;
        end else if (cmd_i.last) begin
          st_d = BK_APPLY;
        end
      end
      BK_DIV:   if (cnt_q == '0) st_d = BK_APPLY;
      BK_APPLY: if (!cmd_q.last) st_d = BK_IDLE;
        else st_d = BK_SETTLE;
      BK_SETTLE: if (seen_q == '0) st_d = BK_EMIT;
        else begin
          div_start = 1'b1;
          div_dvd = psum_q;
          div_dvs = (IndexW+1)'(seen_q);
          div_len = CW'(QW);
          st_d = BK_MEANP;
        end
      BK_MEANP: if (cnt_q == '0) begin
        div_start = 1'b1;
        div_dvd = osum_q;
        div_dvs = (IndexW+1)'(seen_q);
        div_len = CW'(QW);
        st_d = BK_MEANO;
      end
      BK_MEANO: if (cnt_q == '0) st_d = BK_EMIT;
      BK_EMIT: begin
        clear_stats = 1'b1;
        st_d = BK_IDLE;
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BK_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (div_start) begin
      quo_q <= '0; rem_q <= '0; dvd_q <= div_dvd; dvs_q <= div_dvs; cnt_q <= div_len;
    end else if (cnt_q != '0) begin
      rem_q <= rem_ge ? rem_sh - (QW+1)'(dvs_q) : rem_sh;
      quo_q <= {quo_q[QW-2:0], rem_ge};
      dvd_q <= {dvd_q[QW-2:0], 1'b0};
      cnt_q <= cnt_q - 1'b1;
    end
    if (st_q == BK_MEANP && cnt_q == '0) meanp_q <= mean_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0; fall_q <= '0; seen_q <= '0; psum_q <= '0; osum_q <= '0;
      minp_q <= '1; maxp_q <= '0; mino_q <= '1; maxo_q <= '0;
      minp_at_q <= '0; maxp_at_q <= '0; mino_at_q <= '0; maxo_at_q <= '0;
      out_full_q <= 1'b0;
    end else begin
      if (pop_i && out_full_q) out_full_q <= 1'b0;
      if (st_q == BK_APPLY) begin
        case (cmd_q.ev)
          EV_REF:  ref_q <= ctime;
          EV_FALL: fall_q <= ctime;
          EV_CLOSE: begin
            if (seen_q != '1) seen_q <= seen_q + 1'b1;
            if (ont > maxo_q) begin maxo_q <= ont; maxo_at_q <= cmd_q.idx; end
            if (ont < mino_q) begin mino_q <= ont; mino_at_q <= cmd_q.idx; end
            if (per > maxp_q) begin maxp_q <= per; maxp_at_q <= cmd_q.idx; end
            if (per < minp_q) begin minp_q <= per; minp_at_q <= cmd_q.idx; end
            psum_q <= psum_n[SumW] ? '1 : psum_n[SumW-1:0];
            osum_q <= osum_n[SumW] ? '1 : osum_n[SumW-1:0];
            ref_q <= ctime;
          end
          default: ;
        endcase
      end
      if (st_q == BK_EMIT) begin
        out_full_q <= 1'b1;
        period_count_o <= seen_q;
        mean_period_o <= (seen_q == '0) ? '0 : meanp_q;
        mean_on_time_o <= (seen_q == '0) ? '0 : mean_sat;
        shortest_period_o <= (seen_q == '0) ? '0 : minp_q;
        shortest_period_at_o <= minp_at_q;
        longest_period_o <= maxp_q;
        longest_period_at_o <= maxp_at_q;
        shortest_on_time_o <= (seen_q == '0) ? '0 : mino_q;
        shortest_on_time_at_o <= mino_at_q;
        longest_on_time_o <= maxo_q;
        longest_on_time_at_o <= maxo_at_q;
      end
      if (clear_stats) begin
        ref_q <= '0; fall_q <= '0; seen_q <= '0; psum_q <= '0; osum_q <= '0;
        minp_q <= '1; maxp_q <= '0; mino_q <= '1; maxo_q <= '0;
        minp_at_q <= '0; maxp_at_q <= '0; mino_at_q <= '0; maxo_at_q <= '0;
      end
    end
  end

  assign empty_o = !out_full_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_EMIT |=> out_full_q)
    else $error("summary not registered");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> st_q == BK_IDLE && !(cmd_i.last && out_full_q))
    else $error("command taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_DIV |-> dvs_q != '0)
    else $error("divide by zero");
endmodule
`default_nettype wire
